// ===== hw/rtl/pcdt_pkg.sv =====
`timescale 1ns / 1ps

package pcdt_pkg;

	// Number of timer slots, one per output channel (1 to 8).
	localparam int CHANNEL_COUNT = 4;
	localparam int IDX_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

	localparam logic [31:0] MS_PER_SECOND = 32'd1000;
	localparam logic [22:0] MAX_SECONDS   = 23'd4294967;

	// x / 1000 == (x * DIV_MAGIC) >> DIV_SHIFT for every 32-bit unsigned x.
	localparam logic [28:0] DIV_MAGIC = 29'd274877907;
	localparam int          DIV_SHIFT = 38;
	localparam int          PROD_W    = 61;

	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_START  = 2'd1,
		OP_CANCEL = 2'd2,
		OP_QUERY  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_ONE,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		op_t         action;
		logic [2:0]  channel;
		logic [22:0] delay_seconds;
		logic        switch_on;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  report_channel;
		logic        running;
		logic [22:0] seconds_left;
		logic        expiry_action;
		logic        fired;
		logic        last;
	} report_t;

	// Tag that travels with each slot evaluation through the shared unit.
	typedef struct packed {
		op_t        kind;
		logic [2:0] channel;
		logic       action;
		logic       live;
		logic       last;
	} meta_t;

	typedef struct packed {
		logic        valid;
		meta_t       meta;
		logic [31:0] now_ms;
		logic [31:0] start_ms;
		logic [31:0] dur_ms;
	} issue_t;

	typedef struct packed {
		logic  valid;
		meta_t meta;
		logic  expired;
	} eval_t;

	typedef struct packed {
		logic        valid;
		meta_t       meta;
		logic        expired;
		logic [22:0] secs;
	} rem_t;

endpackage

// ===== hw/rtl/per_channel_delay_timer_bank.sv =====
`timescale 1ns / 1ps
// Start, cancel and query: at most one report beat, registered after the shared unit,
// and busy stays high through that beat, so the next command is taken only after it.
// Tick: one slot is walked per cycle through the shared unit, and each active slot
// reports in slot order; busy stays high through the last beat of the walk.
// Reset is asynchronous and active low; it clears every slot and the millisecond count.
// Report beats cannot be held off by the receiver.
module per_channel_delay_timer_bank (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  pcdt_pkg::cmd_t    cmd,
	output logic              report_strobe,
	output pcdt_pkg::report_t report
);
	import pcdt_pkg::*;

	issue_t  issue;
	eval_t   eval;
	rem_t    rem;
	logic    unit_busy;
	logic    report_strobe_q;
	report_t report_q;
	logic    tick_fire;
	logic    counting;

	// The sequencer walks one slot per cycle during a tick and issues an evaluation for
	// each active slot, or at most a single evaluation for the other commands.
	pcdt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.busy      (busy),
		.issue     (issue),
		.eval      (eval),
		.unit_busy (unit_busy)
	);

	// Shared unit: computes expiry and whole seconds left for every report.
	// A start runs through it too, which returns its own saturated duration.
	pcdt_rem_unit u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.issue  (issue),
		.eval   (eval),
		.rem    (rem)
	);

	assign unit_busy = eval.valid || rem.valid;

	// A tick evaluation that has run out fires; anything live and not run out
	// reports its remaining seconds, all else reports zero seconds.
	assign tick_fire = (rem.meta.kind == OP_TICK) && rem.expired;
	assign counting  = rem.meta.live && !rem.expired;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_strobe_q <= 1'b0;
		end else begin
			report_strobe_q <= rem.valid;
		end
	end

	always_ff @(posedge clk) begin
		report_q.report_channel <= rem.meta.channel;
		report_q.running        <= rem.meta.live && !tick_fire;
		report_q.seconds_left   <= counting ? rem.secs : 23'd0;
		report_q.expiry_action  <= rem.meta.action;
		report_q.fired          <= tick_fire;
		report_q.last           <= rem.meta.last;
	end

	assign report_strobe = report_strobe_q;
	assign report        = report_q;

endmodule

// ===== hw/rtl/pcdt_rem_unit.sv =====
`timescale 1ns / 1ps

// Shared remaining-time unit: elapsed time, expiry compare and the divide by
// one thousand, in two register stages. One slot evaluation can enter per cycle.
module pcdt_rem_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  pcdt_pkg::issue_t issue,
	output pcdt_pkg::eval_t  eval,
	output pcdt_pkg::rem_t   rem
);
	import pcdt_pkg::*;

	logic [31:0]       elapsed;
	logic              v_s1;
	meta_t             meta_s1;
	logic              exp_s1;
	logic [31:0]       diff_s1;
	logic              v_s2;
	meta_t             meta_s2;
	logic              exp_s2;
	logic [PROD_W-1:0] prod_s2;

	assign elapsed = issue.now_ms - issue.start_ms;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue.valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		meta_s1 <= issue.meta;
		exp_s1  <= (elapsed >= issue.dur_ms);
		diff_s1 <= issue.dur_ms - elapsed;
		meta_s2 <= meta_s1;
		exp_s2  <= exp_s1;
		prod_s2 <= PROD_W'(diff_s1) * PROD_W'(DIV_MAGIC);
	end

	assign eval.valid   = v_s1;
	assign eval.meta    = meta_s1;
	assign eval.expired = exp_s1;

	assign rem.valid   = v_s2;
	assign rem.meta    = meta_s2;
	assign rem.expired = exp_s2;
	assign rem.secs    = prod_s2[PROD_W-1:DIV_SHIFT];

endmodule

// ===== hw/rtl/pcdt_ctrl.sv =====
`timescale 1ns / 1ps

// Sequencer and slot storage. Feeds slot evaluations to the shared unit and
// applies the state changes of each command.
module pcdt_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  pcdt_pkg::cmd_t   cmd,
	output logic             busy,
	output pcdt_pkg::issue_t issue,
	input  pcdt_pkg::eval_t  eval,
	input  logic             unit_busy
);
	import pcdt_pkg::*;

	state_t            state_q, state_d;
	cmd_t              cmd_q;
	logic [31:0]       cmd_dur_q;
	logic [IDX_W-1:0]  idx_q;
	logic [31:0]       now_q;

	logic              slot_active_q   [CHANNEL_COUNT];
	logic              slot_action_q   [CHANNEL_COUNT];
	logic [31:0]       slot_dur_q      [CHANNEL_COUNT];
	logic [31:0]       slot_start_q    [CHANNEL_COUNT];

	logic              accept;
	logic [22:0]       sat_secs;
	logic              chan_ok;
	logic [IDX_W-1:0]  sel;
	logic              higher_active;
	logic [IDX_W-1:0]  fire_idx;

	assign accept   = start && (state_q == ST_IDLE);
	assign busy     = (state_q != ST_IDLE);
	assign sat_secs = (cmd.delay_seconds > MAX_SECONDS) ? MAX_SECONDS : cmd.delay_seconds;
	assign chan_ok  = ({1'b0, cmd_q.channel} < 4'(CHANNEL_COUNT));
	assign sel      = (state_q == ST_WALK) ? idx_q : cmd_q.channel[IDX_W-1:0];
	assign fire_idx = eval.meta.channel[IDX_W-1:0];

	// Any active slot above the one being walked means this is not the last report.
	always_comb begin
		higher_active = 1'b0;
		for (int j = 0; j < CHANNEL_COUNT; j++) begin
			if (slot_active_q[j] && ((IDX_W + 1)'(j) > {1'b0, idx_q}))
				higher_active = 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept)
					state_d = (cmd.action == OP_TICK) ? ST_WALK : ST_ONE;
			end
			ST_WALK: begin
				if (idx_q == IDX_W'(CHANNEL_COUNT - 1))
					state_d = ST_DRAIN;
			end
			ST_ONE: begin
				state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!unit_busy)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		issue.valid       = 1'b0;
		issue.meta.kind   = cmd_q.action;
		issue.meta.channel = cmd_q.channel;
		issue.meta.action = slot_action_q[sel];
		issue.meta.live   = 1'b0;
		issue.meta.last   = 1'b1;
		issue.now_ms      = now_q;
		issue.start_ms    = slot_start_q[sel];
		issue.dur_ms      = slot_dur_q[sel];
		unique case (state_q)
			ST_WALK: begin
				issue.valid        = slot_active_q[sel];
				issue.meta.kind    = OP_TICK;
				issue.meta.channel = 3'(idx_q);
				issue.meta.live    = 1'b1;
				issue.meta.last    = !higher_active;
			end
			ST_ONE: begin
				unique case (cmd_q.action)
					OP_START: begin
						issue.valid       = chan_ok;
						issue.meta.action = cmd_q.switch_on;
						issue.meta.live   = 1'b1;
						issue.start_ms    = now_q;
						issue.dur_ms      = cmd_dur_q;
					end
					OP_CANCEL: begin
						issue.valid = chan_ok && slot_active_q[sel];
					end
					OP_QUERY: begin
						issue.valid       = 1'b1;
						issue.meta.live   = chan_ok && slot_active_q[sel];
						issue.meta.action = chan_ok && slot_action_q[sel];
					end
					OP_TICK: begin
						issue.valid = 1'b0;
					end
					default: issue.valid = 1'b0;
				endcase
			end
			ST_IDLE, ST_DRAIN: begin
				issue.valid = 1'b0;
			end
			default: issue.valid = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			now_q   <= '0;
			for (int i = 0; i < CHANNEL_COUNT; i++) begin
				slot_active_q[i] <= 1'b0;
				slot_action_q[i] <= 1'b0;
				slot_dur_q[i]    <= '0;
				slot_start_q[i]  <= '0;
			end
		end else begin
			state_q <= state_d;
			if (accept) begin
				idx_q <= '0;
				if (cmd.action == OP_TICK)
					now_q <= now_q + 32'd1;
			end else if (state_q == ST_WALK) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (state_q == ST_ONE && chan_ok) begin
				if (cmd_q.action == OP_START) begin
					slot_active_q[sel] <= 1'b1;
					slot_action_q[sel] <= cmd_q.switch_on;
					slot_dur_q[sel]    <= cmd_dur_q;
					slot_start_q[sel]  <= now_q;
				end else if (cmd_q.action == OP_CANCEL) begin
					slot_active_q[sel] <= 1'b0;
				end
			end
			if (eval.valid && eval.meta.kind == OP_TICK && eval.expired)
				slot_active_q[fire_idx] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= cmd;
			cmd_dur_q <= 32'(32'(sat_secs) * MS_PER_SECOND);
		end
	end

endmodule

// ===== hw/rtl/pcdt_checker.sv =====
`timescale 1ns / 1ps

module pcdt_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              report_strobe,
	input pcdt_pkg::report_t report
);
	import pcdt_pkg::*;

	// An accepted command keeps the block busy in the following cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("block not busy after accepting a command");

	// Report beats only come while a command is in progress.
	a_report_busy: assert property (@(posedge clk) disable iff (!arst_n)
		report_strobe |-> busy)
		else $error("report beat while idle");

	// The final beat of a command is not followed by another beat in the next cycle.
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		report_strobe && report.last |=> !report_strobe)
		else $error("report beat after the final report beat");

	// A stopped timer, fired or not, has no seconds left.
	a_stopped_zero: assert property (@(posedge clk) disable iff (!arst_n)
		report_strobe && (report.fired || !report.running) |->
			!report.running && (report.seconds_left == 23'd0))
		else $error("stopped timer reports running or seconds left");

endmodule

bind per_channel_delay_timer_bank pcdt_checker u_pcdt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.report_strobe (report_strobe),
	.report        (report)
);

// ===== sim/per_channel_delay_timer_bank_tb.sv =====
`timescale 1ns / 1ps

module per_channel_delay_timer_bank_tb;
	import pcdt_pkg::*;

	// A window of this many cycles with neither an accepted command nor a report beat
	// means the block has hung. The longest quiet stretch of a correct run is a tick
	// with no active slot, then the extra wait of a drain and a sender gap.
	localparam int HANG_LIMIT = 2000;
	localparam int RANDOM_CMDS = 270;

	// Keeps its own copy of every slot and the millisecond count, works out the report
	// beats that each accepted command must cause, and compares the beats that come
	// back against them in order.
	class timer_bank_checker;
		bit          slot_live[CHANNEL_COUNT];
		bit          slot_on_at_end[CHANNEL_COUNT];
		logic [22:0] slot_secs[CHANNEL_COUNT];
		logic [31:0] slot_t0[CHANNEL_COUNT];
		logic [31:0] clock_ms;
		report_t     expected_reports[$];
		int          mismatches;
		int          beats_checked;
		int          fired_seen;
		int          op_count[4];

		function new();
			clock_ms = '0;
			mismatches = 0;
			beats_checked = 0;
			fired_seen = 0;
			foreach (slot_live[i]) begin
				slot_live[i] = 1'b0;
				slot_on_at_end[i] = 1'b0;
				slot_secs[i] = '0;
				slot_t0[i] = '0;
			end
			foreach (op_count[i])
				op_count[i] = 0;
		endfunction

		function int pending();
			return expected_reports.size();
		endfunction

		// Whole seconds left on a slot; zero once its time has run out.
		function logic [22:0] secs_left(int i);
			logic [31:0] age;
			logic [31:0] span;
			age = clock_ms - slot_t0[i];
			span = 32'(slot_secs[i]) * MS_PER_SECOND;
			if (age >= span)
				return '0;
			return 23'((span - age) / MS_PER_SECOND);
		endfunction

		function void note_cmd(cmd_t c);
			report_t r;
			report_t held;
			bit      have_held;
			int      ch;
			ch = int'(c.channel);
			r = '0;
			held = '0;
			have_held = 1'b0;
			op_count[int'(c.action)]++;
			case (c.action)
				OP_TICK: begin
					clock_ms = clock_ms + 32'd1;
					// A beat is only pushed once the next one is known, so that the
					// final beat of the walk can carry the last flag.
					for (int i = 0; i < CHANNEL_COUNT; i++) begin
						if (slot_live[i]) begin
							r = '0;
							r.report_channel = 3'(i);
							r.expiry_action = slot_on_at_end[i];
							if (clock_ms - slot_t0[i] >= 32'(slot_secs[i]) * MS_PER_SECOND) begin
								slot_live[i] = 1'b0;
								r.fired = 1'b1;
							end else begin
								r.running = 1'b1;
								r.seconds_left = secs_left(i);
							end
							if (have_held)
								expected_reports.push_back(held);
							held = r;
							have_held = 1'b1;
						end
					end
					if (have_held) begin
						held.last = 1'b1;
						expected_reports.push_back(held);
					end
				end
				OP_START: begin
					if (ch < CHANNEL_COUNT) begin
						slot_live[ch] = 1'b1;
						slot_on_at_end[ch] = c.switch_on;
						slot_secs[ch] = (c.delay_seconds > MAX_SECONDS) ? MAX_SECONDS :
							c.delay_seconds;
						slot_t0[ch] = clock_ms;
						r.report_channel = c.channel;
						r.running = 1'b1;
						r.seconds_left = slot_secs[ch];
						r.expiry_action = c.switch_on;
						r.last = 1'b1;
						expected_reports.push_back(r);
					end
				end
				OP_CANCEL: begin
					if (ch < CHANNEL_COUNT && slot_live[ch]) begin
						slot_live[ch] = 1'b0;
						r.report_channel = c.channel;
						r.expiry_action = slot_on_at_end[ch];
						r.last = 1'b1;
						expected_reports.push_back(r);
					end
				end
				default: begin
					r.report_channel = c.channel;
					r.last = 1'b1;
					if (ch < CHANNEL_COUNT) begin
						r.expiry_action = slot_on_at_end[ch];
						if (slot_live[ch]) begin
							r.running = 1'b1;
							r.seconds_left = secs_left(ch);
						end
					end
					expected_reports.push_back(r);
				end
			endcase
		endfunction

		task flag(string what, int got, int want);
			mismatches++;
			$display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
		endtask

		task check_report(report_t got);
			report_t want;
			if (expected_reports.size() == 0) begin
				flag("report beat with nothing pending, channel", got.report_channel, -1);
			end else begin
				want = expected_reports.pop_front();
				beats_checked++;
				if (got.fired)
					fired_seen++;
				if (got.report_channel != want.report_channel)
					flag("report_channel", got.report_channel, want.report_channel);
				if (got.running != want.running)
					flag("running", got.running, want.running);
				if (got.seconds_left != want.seconds_left)
					flag("seconds_left", got.seconds_left, want.seconds_left);
				if (got.expiry_action != want.expiry_action)
					flag("expiry_action", got.expiry_action, want.expiry_action);
				if (got.fired != want.fired)
					flag("fired", got.fired, want.fired);
				if (got.last != want.last)
					flag("last", got.last, want.last);
			end
		endtask
	endclass

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	cmd_t    cmd_beat = '0;
	logic    busy;
	logic    report_strobe;
	report_t report_beat;

	timer_bank_checker sb;
	int quiet_cycles = 0;

	per_channel_delay_timer_bank dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd_beat),
		.report_strobe(report_strobe),
		.report(report_beat)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Report beats last exactly one cycle and cannot be held off, so every strobe seen
	// at a rising edge is a beat taken by the receiver. Outputs are sampled here
	// before the block's own updates of this edge take effect.
	always @(posedge clk) begin
		if (arst_n && report_strobe)
			sb.check_report(report_beat);
	end

	// Hang detector: resets whenever a command is taken or a report beat arrives.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || report_strobe)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= HANG_LIMIT) begin
				$display("Timed out after %0d quiet cycles", quiet_cycles);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	function automatic cmd_t make_cmd(op_t op, int ch, int secs, bit on);
		cmd_t c;
		c.action = op;
		c.channel = 3'(ch);
		c.delay_seconds = 23'(secs);
		c.switch_on = on;
		return c;
	endfunction

	// Ticks dominate so that timers age and fire; most starts use zero or tiny
	// durations, of which the zero ones expire within the run, while the rest reach the
	// saturation limit and the top bits of the duration field.
	function automatic cmd_t random_cmd();
		cmd_t c;
		int   pick;
		pick = $urandom_range(99);
		if (pick < 45)
			c.action = OP_TICK;
		else if (pick < 70)
			c.action = OP_START;
		else if (pick < 85)
			c.action = OP_CANCEL;
		else
			c.action = OP_QUERY;
		if ($urandom_range(4) == 0)
			c.channel = 3'($urandom_range(7));
		else
			c.channel = 3'($urandom_range(CHANNEL_COUNT - 1));
		pick = $urandom_range(99);
		if (pick < 35)
			c.delay_seconds = '0;
		else if (pick < 55)
			c.delay_seconds = 23'($urandom_range(3));
		else if (pick < 85)
			c.delay_seconds = 23'($urandom);
		else
			c.delay_seconds = 23'($urandom_range(int'(MAX_SECONDS) - 2, int'(MAX_SECONDS) + 2));
		c.switch_on = 1'($urandom);
		return c;
	endfunction

	// Sender gap before a beat: grows by one step with a chance of 23 in a hundred at each draw, zero when calm.
	function automatic int sender_gap(bit calm);
		int gap;
		gap = 0;
		if (!calm) begin
			while ($urandom_range(99) < 23 && gap < 16)
				gap++;
		end
		return gap;
	endfunction

	// Called just after a rising edge. A gap lowers start once, waits for the block to
	// become ready and then holds off for that many edges at which a beat could have
	// been taken; with no gap start stays high from the previous beat so it is never
	// lowered and raised in the same step. The beat is taken at the first edge that
	// sees busy low.
	task automatic send_cmd(cmd_t c, int gap);
		if (gap > 0) begin
			start <= 1'b0;
			do
				@(posedge clk);
			while (busy);
			repeat (gap - 1) @(posedge clk);
		end
		start <= 1'b1;
		cmd_beat <= c;
		do
			@(posedge clk);
		while (busy);
		sb.note_cmd(c);
	endtask

	// Holds the sender off until every expected beat is in. A command with no report
	// may still be in flight, so an extra wait afterwards covers the longest tick walk.
	task automatic drain_reports();
		start <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0 || busy);
		repeat (CHANNEL_COUNT + 6) @(posedge clk);
	endtask

	initial begin
		cmd_t directed[$];
		sb = new();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening: an empty tick, every ignored case, zero-length timers that
		// fire on the next tick, a query on a timer that has run out but is not yet
		// cleared, saturation of an oversize duration, a full four-slot walk,
		// replacement of a running timer, and queries on invalid channels.
		directed.push_back(make_cmd(OP_TICK, 0, 0, 1'b0));
		directed.push_back(make_cmd(OP_QUERY, 7, 23'h7FFFFF, 1'b1));
		directed.push_back(make_cmd(OP_QUERY, 0, 0, 1'b0));
		directed.push_back(make_cmd(OP_CANCEL, 1, 0, 1'b1));
		directed.push_back(make_cmd(OP_START, 7, 5, 1'b1));
		directed.push_back(make_cmd(OP_START, 0, 0, 1'b1));
		directed.push_back(make_cmd(OP_QUERY, 0, 0, 1'b0));
		directed.push_back(make_cmd(OP_TICK, 0, 0, 1'b0));
		directed.push_back(make_cmd(OP_START, 1, int'(MAX_SECONDS), 1'b0));
		directed.push_back(make_cmd(OP_START, 2, 23'h7FFFFF, 1'b1));
		directed.push_back(make_cmd(OP_START, 3, 1, 1'b1));
		directed.push_back(make_cmd(OP_START, 0, 2, 1'b0));
		directed.push_back(make_cmd(OP_TICK, 0, 0, 1'b0));
		directed.push_back(make_cmd(OP_QUERY, 1, 0, 1'b0));
		directed.push_back(make_cmd(OP_QUERY, 3, 0, 1'b0));
		directed.push_back(make_cmd(OP_CANCEL, 2, 0, 1'b0));
		directed.push_back(make_cmd(OP_CANCEL, 2, 0, 1'b0));
		directed.push_back(make_cmd(OP_QUERY, 2, 0, 1'b0));
		directed.push_back(make_cmd(OP_START, 1, 0, 1'b1));
		directed.push_back(make_cmd(OP_TICK, 0, 0, 1'b0));
		directed.push_back(make_cmd(OP_CANCEL, 7, 0, 1'b1));
		directed.push_back(make_cmd(OP_QUERY, 4, 0, 1'b1));
		directed.push_back(make_cmd(OP_TICK, 0, 0, 1'b0));
		foreach (directed[i])
			send_cmd(directed[i], sender_gap(1'b0));
		drain_reports();

		// Random part. Items 90 to 149 go back to back with no sender gaps, and the
		// sender stops halfway until the scoreboard has emptied.
		for (int i = 0; i < RANDOM_CMDS; i++) begin
			send_cmd(random_cmd(), sender_gap(i >= 90 && i < 150));
			if (i == RANDOM_CMDS / 2)
				drain_reports();
		end
		drain_reports();

		$display("Sent %0d ticks, %0d starts, %0d cancels, %0d queries.",
			sb.op_count[int'(OP_TICK)], sb.op_count[int'(OP_START)],
			sb.op_count[int'(OP_CANCEL)], sb.op_count[int'(OP_QUERY)]);
		$display("Checked %0d report beats, %0d of them timer expiries.",
			sb.beats_checked, sb.fired_seen);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("%0d mismatches, %0d beats never arrived", sb.mismatches, sb.pending());
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/pcdt_pkg.sv
hw/rtl/pcdt_rem_unit.sv
hw/rtl/pcdt_ctrl.sv
hw/rtl/per_channel_delay_timer_bank.sv
hw/rtl/pcdt_checker.sv
sim/per_channel_delay_timer_bank_tb.sv
